[design/tbip_pkg.sv]
// Shared types, constants and lookup functions for the telemetry bit interleave packer.
// Used by tbip_bitgen and telemetry_bit_interleave_packer_top; depends on nothing.
package tbip_pkg;

   localparam logic [2:0]  MARK_CODE  = 3'b110;
   localparam logic [2:0]  SET_SILENT = 3'd6;
   localparam logic [2:0]  SET_TEXT   = 3'd7;
   // Fixed text of the identification packet, first character in the top byte.
   localparam logic [63:0] TEXT_BITS  = 64'h556E_6974_4C4E_450A;

   typedef enum logic [5:0] {
      GEN_IDLE  = 6'b000001,
      GEN_MARK  = 6'b000010,
      GEN_SETN  = 6'b000100,
      GEN_PAD   = 6'b001000,
      GEN_TEXT  = 6'b010000,
      GEN_FIELD = 6'b100000
   } gen_state_type;

   typedef struct packed {
      logic bit_valid;
      logic bit_value;
      logic busy;
   } gen_out_type;

   function automatic logic [4:0] field_width(input logic [2:0] set_id, input logic [1:0] fld);
      logic [4:0] w;
      w = 5'd0;
      unique case (set_id)
         3'd0: w = (fld == 2'd3) ? 5'd0 : 5'd16;
         3'd1: w = (fld == 2'd3) ? 5'd0 : 5'd12;
         3'd2: w = (fld == 2'd0) ? 5'd8 : ((fld == 2'd3) ? 5'd0 : 5'd16);
         3'd3, 3'd4: w = 5'd16;
         3'd5: w = (fld == 2'd0) ? 5'd16 : ((fld == 2'd1) ? 5'd12 : 5'd0);
         default: w = 5'd0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] packet_len(input logic [2:0] set_id, input logic rev);
      logic [6:0] total;
      logic [6:0] rounded;
      total = 7'd3;
      if (set_id == SET_TEXT) begin
         total = 7'd72;
      end else begin
         if (rev) begin
            total = total + 7'd3;
         end
         total = total + {2'b00, field_width(set_id, 2'd0)} + {2'b00, field_width(set_id, 2'd1)}
                       + {2'b00, field_width(set_id, 2'd2)} + {2'b00, field_width(set_id, 2'd3)};
      end
      rounded = total + 7'd7;
      return rounded[6:3];
   endfunction

endpackage

[design/tbip_bitgen.sv]
// Packer bit sequencer over marker, set number, padding, text or round-robin field
// interleave: at most one bit per cycle, while advance is high. Uses tbip_pkg.
module tbip_bitgen
   import tbip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  set_id,
   input  logic        reverse,
   input  logic [15:0] field_a,
   input  logic [15:0] field_b,
   input  logic [15:0] field_c,
   input  logic [15:0] field_d,
   input  logic        advance,
   output gen_out_type gen_out
);

   gen_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [3:0]  round_ff, round_in;
   logic [1:0]  slot_ff, slot_in;
   logic [2:0]  set_ff, set_in;
   logic        rev_ff, rev_in;
   logic [15:0] field_ff [4];
   logic [15:0] field_in [4];

   logic [1:0] fsel;
   logic [4:0] wsel;
   logic       in_range;
   logic [4:0] bidx_full;
   logic [3:0] bidx;
   logic       field_bit;
   logic       bit_valid;
   logic       bit_value;

   // Forward mode visits a,b,c,d; reverse visits d,c,b,a.
   assign fsel      = rev_ff ? ~slot_ff : slot_ff;
   assign wsel      = field_width(set_ff, fsel);
   assign in_range  = {1'b0, round_ff} < wsel;
   assign bidx_full = rev_ff ? {1'b0, round_ff} : (wsel - 5'd1 - {1'b0, round_ff});
   assign bidx      = bidx_full[3:0];
   assign field_bit = field_ff[fsel][bidx];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      round_in  = round_ff;
      slot_in   = slot_ff;
      set_in    = set_ff;
      rev_in    = rev_ff;
      field_in  = field_ff;
      bit_valid = 1'b0;
      bit_value = 1'b0;
      unique case (state_ff)
         GEN_IDLE: begin
            if (start && set_id != SET_SILENT) begin
               set_in      = set_id;
               rev_in      = reverse;
               field_in[0] = field_a;
               field_in[1] = field_b;
               field_in[2] = field_c;
               field_in[3] = field_d;
               cnt_in      = 6'd0;
               state_in    = (reverse && set_id != SET_TEXT) ? GEN_MARK : GEN_SETN;
            end
         end
         GEN_MARK: begin
            bit_valid = advance;
            bit_value = MARK_CODE[2'd2 - cnt_ff[1:0]];
            if (advance) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd2) begin
                  cnt_in   = 6'd0;
                  state_in = GEN_SETN;
               end
            end
         end
         GEN_SETN: begin
            bit_valid = advance;
            bit_value = set_ff[2'd2 - cnt_ff[1:0]];
            if (advance) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd2) begin
                  cnt_in   = 6'd0;
                  round_in = 4'd0;
                  slot_in  = 2'd0;
                  state_in = (set_ff == SET_TEXT) ? GEN_PAD : GEN_FIELD;
               end
            end
         end
         GEN_PAD: begin
            bit_valid = advance;
            if (advance) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd4) begin
                  cnt_in   = 6'd0;
                  state_in = GEN_TEXT;
               end
            end
         end
         GEN_TEXT: begin
            bit_valid = advance;
            bit_value = TEXT_BITS[~cnt_ff];
            if (advance) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_in = GEN_IDLE;
               end
            end
         end
         GEN_FIELD: begin
            // A slot whose field is already spent still takes a step but yields no bit.
            bit_valid = advance && in_range;
            bit_value = field_bit;
            if (advance) begin
               slot_in = slot_ff + 2'd1;
               if (slot_ff == 2'd3) begin
                  round_in = round_ff + 4'd1;
                  if (round_ff == 4'd15) begin
                     state_in = GEN_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
         cnt_ff   <= 6'd0;
         round_ff <= 4'd0;
         slot_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         round_ff <= round_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff   <= set_in;
      rev_ff   <= rev_in;
      field_ff <= field_in;
   end

   assign gen_out.bit_valid = bit_valid;
   assign gen_out.bit_value = bit_value;
   assign gen_out.busy      = (state_ff != GEN_IDLE);

   a_text_only_set7: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GEN_TEXT || state_ff == GEN_PAD) |-> (set_ff == SET_TEXT))
      else $error("text phase entered for a data set");
   a_field_not_set7: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GEN_FIELD) |-> (set_ff != SET_TEXT && set_ff != SET_SILENT))
      else $error("field interleave running for text or silent set");
   a_mark_only_rev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GEN_MARK) |-> rev_ff)
      else $error("reversal marker sent in forward mode");

endmodule

[design/telemetry_bit_interleave_packer_top.sv]
// Telemetry bit interleave packer. A request beat carries a set number, a reverse
// flag and four 16-bit samples; the block answers with one response beat per packet
// byte, first packet bit in bit 7. Each beat also carries the byte index, the packet
// length in bytes and a last flag on the final byte. Set 6 accepts the request and
// returns nothing.
// The bit sequencer in tbip_bitgen takes one step per cycle while the byte being
// assembled has room: 67 steps in the field sets (70 with the reversal marker) and
// 72 for set 7; a field slot that is already spent costs a step without a bit. Each
// finished byte then moves into the response register, the last byte is padded with
// zero bits, and the packet is then retired.
// req_stall stays high from acceptance until the cycle after the last byte enters the
// response register, so a new request can be taken while that byte waits to be taken.
// When the receiver stalls, the byte in the response register holds, the next byte is
// assembled behind it and the sequencer pauses until the register frees.
// Synchronous reset empties the response register and returns the sequencer to idle.
// Depends on tbip_pkg and tbip_bitgen.
module telemetry_bit_interleave_packer_top
   import tbip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_set_id,
   input  logic        req_reverse,
   input  logic [15:0] req_field_a,
   input  logic [15:0] req_field_b,
   input  logic [15:0] req_field_c,
   input  logic [15:0] req_field_d,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_byte_index,
   output logic [3:0]  rsp_packet_len,
   output logic        rsp_last
);

   logic        active_ff, active_in;
   logic [3:0]  nbits_ff, nbits_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  len_ff, len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic [3:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_accept;
   logic        rsp_free;
   logic        gen_advance;
   gen_out_type gen_out;

   assign req_stall   = active_ff;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign gen_advance = (nbits_ff < 4'd8);

   tbip_bitgen u_bitgen (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .set_id  (req_set_id),
      .reverse (req_reverse),
      .field_a (req_field_a),
      .field_b (req_field_b),
      .field_c (req_field_c),
      .field_d (req_field_d),
      .advance (gen_advance),
      .gen_out (gen_out)
   );

   always_comb begin
      active_in    = active_ff;
      nbits_in     = nbits_ff;
      byte_in      = byte_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_index_in = rsp_index_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_accept) begin
         active_in = (req_set_id != SET_SILENT);
         len_in    = packet_len(req_set_id, req_reverse);
         idx_in    = 4'd0;
         nbits_in  = 4'd0;
      end else if (active_ff) begin
         if (nbits_ff == 4'd8) begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff;
               rsp_index_in = idx_ff;
               rsp_len_in   = len_ff;
               rsp_last_in  = (idx_ff == len_ff - 4'd1);
               idx_in       = idx_ff + 4'd1;
               nbits_in     = 4'd0;
            end
         end else if (gen_out.bit_valid) begin
            byte_in  = {byte_ff[6:0], gen_out.bit_value};
            nbits_in = nbits_ff + 4'd1;
         end else if (!gen_out.busy) begin
            // Stream finished: pad a partial byte with zeros, or retire the packet.
            if (nbits_ff == 4'd0) begin
               active_in = 1'b0;
            end else begin
               byte_in  = {byte_ff[6:0], 1'b0};
               nbits_in = nbits_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         nbits_ff     <= 4'd0;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         nbits_ff     <= nbits_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      len_ff       <= len_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_packet_len = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;

   a_nbits_bound: assert property (@(posedge clock) disable iff (reset)
      nbits_ff <= 4'd8)
      else $error("byte assembly overran eight bits");
   a_gen_idle_when_free: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !gen_out.busy)
      else $error("sequencer busy while no packet is in progress");
   a_index_in_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff < rsp_len_ff))
      else $error("response byte index beyond packet length");
   a_no_bit_when_full: assert property (@(posedge clock) disable iff (reset)
      gen_out.bit_valid |-> (nbits_ff < 4'd8))
      else $error("sequencer offered a bit while the byte was full");

endmodule

[test/tb_telemetry_bit_interleave_packer_top.sv]
// Self-checking testbench for telemetry_bit_interleave_packer_top: a table of directed
// requests then random ones; packets predicted bit by bit or typed in, checked beat by beat.
// Depends on tbip_pkg and the packer RTL only.
module tb_telemetry_bit_interleave_packer_top
   import tbip_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [63:0] ID_TEXT = {"UnitLNE", 8'h0A};

   typedef struct packed {
      logic [2:0]  set_id;
      logic        reverse;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic [15:0] d;
      logic        known;       // packet typed in below instead of predicted
      logic [3:0]  known_len;
      logic [71:0] known_bits;  // first packet bit in bit 71
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic [3:0] index;
      logic [3:0] len;
      logic       last;
   } rsp_beat_type;

   localparam int NUM_DIRECTED = 16;
   localparam stim_row_type DIRECTED_TABLE [0:NUM_DIRECTED-1] = '{
      '{3'd7, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd9, 72'hE0556E69744C4E450A},
      '{3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd9, 72'hE0556E69744C4E450A},
      '{3'd6, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd0, 72'h0},
      '{3'd6, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 72'h0},
      '{3'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd7, 72'h0},
      '{3'd3, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd9, 72'h600000000000000000},
      '{3'd4, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd9, 72'hD3FFFFFFFFFFFFFFFC},
      '{3'd0, 1'b1, 16'h8000, 16'h0001, 16'hFFFF, 16'hAAAA, 1'b0, 4'd0, 72'h0},
      '{3'd1, 1'b0, 16'hFFFF, 16'h0000, 16'hF555, 16'h1234, 1'b0, 4'd0, 72'h0},
      '{3'd1, 1'b1, 16'h0FFF, 16'hF000, 16'h0800, 16'hFFFF, 1'b0, 4'd0, 72'h0},
      '{3'd2, 1'b0, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h0000, 1'b0, 4'd0, 72'h0},
      '{3'd2, 1'b1, 16'h00FF, 16'hFF00, 16'h5A5A, 16'hFFFF, 1'b0, 4'd0, 72'h0},
      '{3'd5, 1'b0, 16'hFFFF, 16'h0FFF, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 72'h0},
      '{3'd5, 1'b1, 16'h8000, 16'h0801, 16'h0000, 16'h0000, 1'b0, 4'd0, 72'h0},
      '{3'd3, 1'b1, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 72'h0},
      '{3'd4, 1'b0, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 1'b0, 4'd0, 72'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_set_id = 3'd0;
   logic        req_reverse = 1'b0;
   logic [15:0] req_field_a = 16'h0000;
   logic [15:0] req_field_b = 16'h0000;
   logic [15:0] req_field_c = 16'h0000;
   logic [15:0] req_field_d = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [3:0]  rsp_byte_index;
   logic [3:0]  rsp_packet_len;
   logic        rsp_last;

   stim_row_type request_q [$];
   rsp_beat_type pending_bytes_q [$];
   int        send_idx = 0;
   int        accept_count = 0;
   int        beat_count = 0;
   int        err_count = 0;
   int        cycle_count = 0;
   int        burst_left = 1;
   int        gap_left = 0;
   int        stall_mode = 0;
   int        stall_mode_left = 0;
   int        stall_tick = 0;

   telemetry_bit_interleave_packer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_set_id     (req_set_id),
      .req_reverse    (req_reverse),
      .req_field_a    (req_field_a),
      .req_field_b    (req_field_b),
      .req_field_c    (req_field_c),
      .req_field_d    (req_field_d),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_packet_len (rsp_packet_len),
      .rsp_last       (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic int lane_width(input logic [2:0] set_id, input int lane);
      case (set_id)
         3'd0: return (lane < 3) ? 16 : 0;
         3'd1: return (lane < 3) ? 12 : 0;
         3'd2: return (lane == 0) ? 8 : ((lane < 3) ? 16 : 0);
         3'd3, 3'd4: return 16;
         3'd5: return (lane == 0) ? 16 : ((lane == 1) ? 12 : 0);
         default: return 0;
      endcase
   endfunction

   function automatic void put_bit(inout logic [71:0] bits, inout int pos, input logic b);
      if (pos < 72) begin
         bits[71 - pos] = b;
         pos++;
      end
   endfunction

   // Builds the whole packet left-aligned in bits and returns its length in bytes.
   function automatic void pack_telemetry(input stim_row_type r, output logic [71:0] bits,
                                          output logic [3:0] nbytes);
      logic [15:0] lane [4];
      int          pos;
      int          w;
      int          f;
      bits = '0;
      pos = 0;
      nbytes = 4'd0;
      lane[0] = r.a;
      lane[1] = r.b;
      lane[2] = r.c;
      lane[3] = r.d;
      if (r.set_id == SET_SILENT) begin
         return;
      end
      if (r.reverse && r.set_id != SET_TEXT) begin
         for (int i = 2; i >= 0; i--) put_bit(bits, pos, MARK_CODE[i]);
      end
      for (int i = 2; i >= 0; i--) put_bit(bits, pos, r.set_id[i]);
      if (r.set_id == SET_TEXT) begin
         for (int i = 0; i < 5; i++) put_bit(bits, pos, 1'b0);
         for (int i = 63; i >= 0; i--) put_bit(bits, pos, ID_TEXT[i]);
      end else begin
         // One bit per live lane per round; reverse walks the lanes d..a from bit 0 up.
         for (int rnd = 0; rnd < 16; rnd++) begin
            for (int k = 0; k < 4; k++) begin
               f = r.reverse ? 3 - k : k;
               w = lane_width(r.set_id, f);
               if (rnd < w) begin
                  put_bit(bits, pos, r.reverse ? lane[f][rnd] : lane[f][w - 1 - rnd]);
               end
            end
         end
      end
      nbytes = 4'((pos + 7) / 8);
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001 << $urandom_range(0, 15);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want_v,
                                  input int unsigned got_v);
      $display("mismatch on %s at response beat %0d: expected %0h, got %0h",
               what, beat_count, want_v, got_v);
      err_count++;
   endtask

   initial begin : build_stimulus
      stim_row_type row;
      foreach (DIRECTED_TABLE[i]) request_q.push_back(DIRECTED_TABLE[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         row = '0;
         row.set_id  = ($urandom_range(0, 9) == 0) ? SET_SILENT : 3'($urandom_range(0, 7));
         row.reverse = 1'($urandom);
         row.a = random_sample();
         row.b = random_sample();
         row.c = random_sample();
         row.d = random_sample();
         request_q.push_back(row);
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: bursts of requests separated by random gaps, some of them empty.
   always @(posedge clock) begin : drive_requests
      stim_row_type nxt;
      logic      taken;
      if (!reset) begin
         taken = req_valid && !req_stall;
         if (taken) begin
            send_idx++;
         end
         if (req_valid && !taken) begin
            // hold the stalled beat as it is
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (send_idx < request_q.size()) begin
            nxt = request_q[send_idx];
            req_valid   <= 1'b1;
            req_set_id  <= nxt.set_id;
            req_reverse <= nxt.reverse;
            req_field_a <= nxt.a;
            req_field_b <= nxt.b;
            req_field_c <= nxt.c;
            req_field_d <= nxt.d;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 5);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: switches between no stall, random stall, alternating stall and long stalls.
   always @(posedge clock) begin
      if (!reset) begin
         stall_tick++;
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 300);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= stall_tick[0];
            default: rsp_stall <= (stall_tick[5:3] == 3'b101);
         endcase
      end
   end

   always @(posedge clock) begin : track_packets
      stim_row_type cur;
      logic [71:0]  bits;
      logic [3:0]   nbytes;
      rsp_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            cur = request_q[accept_count];
            accept_count++;
            if (cur.known) begin
               bits = cur.known_bits;
               nbytes = cur.known_len;
            end else begin
               pack_telemetry(cur, bits, nbytes);
            end
            for (int k = 0; k < nbytes; k++) begin
               want.data  = bits[71 - 8 * k -: 8];
               want.index = 4'(k);
               want.len   = nbytes;
               want.last  = (k == nbytes - 1);
               pending_bytes_q.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_bytes_q.size() == 0) begin
               report_mismatch("unexpected beat, byte", 0, rsp_out_byte);
            end else begin
               want = pending_bytes_q.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", want.data, rsp_out_byte);
               if (rsp_byte_index !== want.index)
                  report_mismatch("byte_index", want.index, rsp_byte_index);
               if (rsp_packet_len !== want.len)
                  report_mismatch("packet_len", want.len, rsp_packet_len);
               if (rsp_last !== want.last)
                  report_mismatch("last", want.last, rsp_last);
            end
            beat_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      while (send_idx < request_q.size() || req_valid) @(posedge clock);
      while (pending_bytes_q.size() != 0) @(posedge clock);
      // Keep watching for a while so that any extra beat is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_bytes_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
design/tbip_pkg.sv
design/tbip_bitgen.sv
design/telemetry_bit_interleave_packer_top.sv
test/tb_telemetry_bit_interleave_packer_top.sv
